FILE: hdl/atslp_pkg.sv
// shared types, character codes and field helpers for the time-sync line parser
// no dependencies
`timescale 1ns / 1ps

package atslp_pkg;

	localparam logic [7:0] CHAR_T    = 8'h54;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// only the first bytes of a line can take part in a valid command
	localparam int LINE_KEEP = 15;
	localparam int SHORT_LEN = 7;
	localparam int FULL_LEN  = 15;

	localparam logic [6:0]  HOURS_LIMIT   = 7'd24;
	localparam logic [6:0]  MINUTES_LIMIT = 7'd60;
	localparam logic [6:0]  MONTH_MAX     = 7'd12;
	localparam logic [6:0]  DAY_MAX       = 7'd31;
	localparam logic [13:0] CENTURY_SCALE = 14'd100;

	typedef logic [LINE_KEEP-1:0][7:0] line_t;

	typedef struct packed {
		logic        time_valid;
		logic        full_date;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
	} result_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	endfunction

	// valid only when both bytes are digits
	function automatic logic [6:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
		return {3'b000, hi[3:0]} * 7'd10 + {3'b000, lo[3:0]};
	endfunction

endpackage

FILE: hdl/atslp_line_eval.sv
// decodes a completed line into a time result
// depends on atslp_pkg
`timescale 1ns / 1ps

module atslp_line_eval (
	input  atslp_pkg::line_t   line,
	input  logic               len_short,
	input  logic               len_full,
	output atslp_pkg::result_t res
);

	logic [atslp_pkg::LINE_KEEP-1:0] dig;
	logic        short_ok;
	logic        full_ok;
	logic [6:0]  yr_hi;
	logic [6:0]  yr_lo;
	logic [6:0]  mo;
	logic [6:0]  dy;
	logic [6:0]  h;
	logic [6:0]  m;
	logic [6:0]  s;
	logic [13:0] yr;
	logic        date_ok;
	logic        time_ok;

	always_comb begin
		for (int i = 0; i < atslp_pkg::LINE_KEEP; i++) begin
			dig[i] = atslp_pkg::is_digit(line[i]);
		end
	end

	assign short_ok = len_short && (line[0] == atslp_pkg::CHAR_T) && (&dig[6:1]);
	assign full_ok  = len_full && (line[0] == atslp_pkg::CHAR_T) && (&dig[14:1]);

	assign yr_hi = atslp_pkg::two_digits(line[1], line[2]);
	assign yr_lo = atslp_pkg::two_digits(line[3], line[4]);
	assign mo    = atslp_pkg::two_digits(line[5], line[6]);
	assign dy    = atslp_pkg::two_digits(line[7], line[8]);
	assign yr    = {7'd0, yr_hi} * atslp_pkg::CENTURY_SCALE + {7'd0, yr_lo};

	// time fields sit right after the date in the long form
	always_comb begin
		if (len_full) begin
			h = atslp_pkg::two_digits(line[9], line[10]);
			m = atslp_pkg::two_digits(line[11], line[12]);
			s = atslp_pkg::two_digits(line[13], line[14]);
		end else begin
			h = atslp_pkg::two_digits(line[1], line[2]);
			m = atslp_pkg::two_digits(line[3], line[4]);
			s = atslp_pkg::two_digits(line[5], line[6]);
		end
	end

	assign date_ok = (mo != 7'd0) && (mo <= atslp_pkg::MONTH_MAX)
		&& (dy != 7'd0) && (dy <= atslp_pkg::DAY_MAX);
	assign time_ok = (h < atslp_pkg::HOURS_LIMIT) && (m < atslp_pkg::MINUTES_LIMIT)
		&& (s < atslp_pkg::MINUTES_LIMIT);

	always_comb begin
		res = '0;
		if (short_ok && time_ok) begin
			res.time_valid = 1'b1;
			res.hours      = h[4:0];
			res.minutes    = m[5:0];
			res.seconds    = s[5:0];
		end else if (full_ok && date_ok && time_ok) begin
			res.time_valid = 1'b1;
			res.full_date  = 1'b1;
			res.year       = yr;
			res.month      = mo[3:0];
			res.day        = dy[4:0];
			res.hours      = h[4:0];
			res.minutes    = m[5:0];
			res.seconds    = s[5:0];
		end
	end

endmodule

FILE: hdl/ascii_time_sync_line_parser_top.sv
// time-sync line parser: gathers received bytes into lines and decodes time commands
// depends on atslp_pkg and atslp_line_eval
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid / in_ready / rx_byte carries one received character per
//   transfer. Output channel out_valid / out_ready carries one result per line that
//   a CR or LF ends; empty lines give nothing, and on overflow the bytes so far are dropped.
//   A result holds time_valid, full_date and the decoded year, month, day, hours,
//   minutes and seconds; every field is zero when the line is not a valid command,
//   and the date fields are zero for the time-only form.
//   Throughput: one byte per cycle while in_ready is high. The line decode is short
//   combinational logic between the line registers and the result register.
//   Latency: the result appears on out_valid in the cycle after the transfer of the
//   terminating byte, provided the output register is free.
//   Stall: results go to an output register backed by one skid entry, so bytes keep
//   flowing while one result waits; in_ready drops only when both are occupied.
//   Reset (arst_n low): line length returns to zero and any pending result is
//   discarded. The line bytes themselves are not cleared.
module ascii_time_sync_line_parser_top #(
	parameter int LINE_BUFFER_BYTES = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        time_valid,
	output logic        full_date,
	output logic [13:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hours,
	output logic [5:0]  minutes,
	output logic [5:0]  seconds
);

	localparam int LINE_CAP = LINE_BUFFER_BYTES - 1;
	localparam int LEN_W    = $clog2(LINE_BUFFER_BYTES);

	logic [LEN_W-1:0]   line_len_q;
	atslp_pkg::line_t   line_q;
	atslp_pkg::result_t res;
	atslp_pkg::result_t out_q;
	atslp_pkg::result_t skid_q;
	logic               out_valid_q;
	logic               skid_valid_q;

	logic in_xfer;
	logic is_term;
	logic produce;
	logic out_free;
	logic load_from_skid;
	logic load_new_out;
	logic load_skid;
	logic store_byte;

	assign in_ready = !skid_valid_q;
	assign in_xfer  = in_valid && in_ready;
	assign is_term  = (rx_byte == atslp_pkg::CHAR_LF) || (rx_byte == atslp_pkg::CHAR_CR);
	assign produce  = in_xfer && is_term && (line_len_q != '0);

	assign store_byte = in_xfer && !is_term
		&& (line_len_q < LEN_W'(LINE_CAP))
		&& (line_len_q < LEN_W'(atslp_pkg::LINE_KEEP));

	atslp_line_eval u_eval (
		.line      (line_q),
		.len_short (line_len_q == LEN_W'(atslp_pkg::SHORT_LEN)),
		.len_full  (line_len_q == LEN_W'(atslp_pkg::FULL_LEN)),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
		end else if (in_xfer) begin
			if (is_term) begin
				line_len_q <= '0;
			end else if (line_len_q < LEN_W'(LINE_CAP)) begin
				line_len_q <= line_len_q + LEN_W'(1);
			end else begin
				// overflow byte dropped, line restarts
				line_len_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_byte) begin
			line_q[line_len_q[3:0]] <= rx_byte;
		end
	end

	assign out_free       = !out_valid_q || out_ready;
	assign load_from_skid = skid_valid_q && out_ready;
	assign load_new_out   = produce && out_free;
	assign load_skid      = produce && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (load_from_skid || load_new_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_skid) begin
				skid_valid_q <= 1'b1;
			end else if (load_from_skid) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			out_q <= skid_q;
		end else if (load_new_out) begin
			out_q <= res;
		end
		if (load_skid) begin
			skid_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign time_valid = out_q.time_valid;
	assign full_date  = out_q.full_date;
	assign year       = out_q.year;
	assign month      = out_q.month;
	assign day        = out_q.day;
	assign hours      = out_q.hours;
	assign minutes    = out_q.minutes;
	assign seconds    = out_q.seconds;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_len_q <= LEN_W'(LINE_CAP))
		else $error("line length beyond capacity");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !time_valid) |-> (out_q == '0))
		else $error("invalid line result carries nonzero fields");

	a_short_no_date: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !full_date) |-> (year == '0 && month == '0 && day == '0))
		else $error("time-only result carries date fields");

	a_term_clears_len: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && is_term) |=> (line_len_q == '0))
		else $error("line length not cleared after terminator");
`endif

endmodule
